// File: src/pmss_pkg.sv
`default_nettype none

package pmss_pkg;

  localparam int unsigned ColW        = 9;
  localparam int unsigned RowW        = 9;
  localparam int unsigned SerialW     = 12;
  localparam int unsigned StageCntW   = 13;
  localparam int unsigned StageW      = 12;
  localparam int unsigned RemBitsStep = 4;   // dividend bits retired per remainder stage
  localparam int unsigned NbSlots     = 8;

  typedef enum logic [2:0] {
    RegMaskType     = 3'd0,
    RegNbPattern    = 3'd1,
    RegSensorType   = 3'd2,
    RegEdgeMode     = 3'd3,
    RegStageCount   = 3'd4,
    RegCurrentStage = 3'd5,
    RegApplyEnable  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MaskStd         = 2'd0,
    MaskXtalkNb     = 2'd1,
    MaskXtalkCentre = 2'd2,
    MaskTot         = 2'd3
  } mask_type_e;

  localparam logic [1:0] SensorSquare = 2'd0;
  localparam logic [1:0] SensorUpDown = 2'd1;
  localparam logic [1:0] SensorDownUp = 2'd2;
  localparam logic [1:0] SensorOther  = 2'd3;

  localparam logic [1:0] EdgeKeep   = 2'd0;
  localparam logic [1:0] EdgeCorner = 2'd2;

  typedef struct packed {
    mask_type_e                 mask_type;
    logic [3:0]                 nb_pattern;
    logic [1:0]                 sensor_type;
    logic [1:0]                 edge_mode;
    logic [StageCntW-1:0]       stage_count;
    logic [StageW-1:0]          current_stage;
    logic                       apply_enable;
  } cfg_t;

  typedef struct packed {
    logic [ColW-1:0]    col;
    logic [RowW-1:0]    row;
    logic [NbSlots-1:0] nb_mask;  // neighbours to emit, already bounds-checked
    logic               ok;       // passed bounds, edge and enable filters
  } item_t;

  typedef logic signed [2:0] nb_off_t;

  // [sensor][column parity][slot]
  localparam nb_off_t NbDcol [4][2][NbSlots] = '{
    '{ '{3'sd0, 3'sd1, 3'sd1, 3'sd1, 3'sd0, -3'sd1, -3'sd1, -3'sd1},
       '{3'sd0, 3'sd1, 3'sd1, 3'sd1, 3'sd0, -3'sd1, -3'sd1, -3'sd1} },
    '{ '{3'sd1, 3'sd3, 3'sd2, 3'sd3, 3'sd1, -3'sd1, -3'sd2, -3'sd1},
       '{-3'sd1, 3'sd1, 3'sd2, 3'sd1, -3'sd1, -3'sd3, -3'sd2, -3'sd3} },
    '{ '{3'sd1, 3'sd3, 3'sd2, 3'sd3, 3'sd1, -3'sd1, -3'sd2, -3'sd1},
       '{-3'sd1, 3'sd1, 3'sd2, 3'sd1, -3'sd1, -3'sd3, -3'sd2, -3'sd3} },
    '{ '{3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
       '{3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0} }
  };

  localparam nb_off_t NbDrow [4][2][NbSlots] = '{
    '{ '{3'sd1, 3'sd1, 3'sd0, -3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd1},
       '{3'sd1, 3'sd1, 3'sd0, -3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd1} },
    '{ '{3'sd0, 3'sd0, 3'sd0, -3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0},
       '{3'sd1, 3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd1} },
    '{ '{3'sd1, 3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd1},
       '{3'sd0, 3'sd0, 3'sd0, -3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0} },
    '{ '{3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
       '{3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0} }
  };

  // bit i set: neighbour slot i is used; patterns above eleven pick none
  localparam logic [NbSlots-1:0] NbPatternBits [16] = '{
    8'hFF, 8'h55, 8'h11, 8'h44, 8'h10, 8'h01, 8'h04, 8'h40,
    8'h08, 8'h20, 8'h02, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

`default_nettype wire

// File: src/pmss_front.sv
`default_nettype none

module pmss_front #(
  parameter int unsigned COLUMNS = 400,
  parameter int unsigned ROWS    = 384
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pmss_pkg::cfg_t                    cfg_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [pmss_pkg::ColW-1:0]         in_col_i,
  input  wire logic [pmss_pkg::RowW-1:0]         in_row_i,
  input  wire logic                              in_en_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output pmss_pkg::item_t                        out_item_o,
  output logic [pmss_pkg::SerialW-1:0]           out_serial_o
);

  localparam logic [10:0] ColLim   = 11'(COLUMNS);
  localparam logic [10:0] ColLast  = 11'(COLUMNS - 1);
  localparam logic [10:0] ColLast2 = 11'(COLUMNS - 2);
  localparam logic [10:0] RowLim   = 11'(ROWS);
  localparam logic [10:0] RowLast  = 11'(ROWS - 1);

  logic                          s1_valid_q, s1_valid_d;
  logic [pmss_pkg::ColW-1:0]     s1_col_q;
  logic [pmss_pkg::RowW-1:0]     s1_row_q;
  logic                          s1_en_q;
  logic                          s2_valid_q, s2_valid_d;
  pmss_pkg::item_t               s2_item_q, s2_item_d;
  logic [pmss_pkg::SerialW-1:0]  s2_serial_q, s2_serial_d;
  logic                          s1_ready, s2_ready;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_col_q <= in_col_i;
      s1_row_q <= in_row_i;
      s1_en_q  <= in_en_i;
    end
    if (s2_ready) begin
      s2_item_q   <= s2_item_d;
      s2_serial_q <= s2_serial_d;
    end
  end

  always_comb begin
    logic [10:0]       col_w;
    logic [10:0]       row_w;
    logic              in_bounds;
    logic              edge_drop;
    logic              odd;
    logic [5:0]        blk_row;
    logic [2:0]        core_col;
    logic              xtalk;
    logic [7:0]        pat;
    pmss_pkg::nb_off_t dc;
    pmss_pkg::nb_off_t dr;
    logic signed [11:0] nc;
    logic signed [11:0] nr;

    col_w     = {2'b00, s1_col_q};
    row_w     = {2'b00, s1_row_q};
    odd       = s1_col_q[0];
    in_bounds = (col_w < ColLim) && (row_w < RowLim);

    if (cfg_i.edge_mode == pmss_pkg::EdgeCorner) begin
      edge_drop = !((s1_col_q == '0) && (s1_row_q == '0));
    end else if (cfg_i.edge_mode == pmss_pkg::EdgeKeep) begin
      edge_drop = 1'b0;
    end else if (cfg_i.sensor_type == pmss_pkg::SensorSquare) begin
      edge_drop = (col_w == '0) || (col_w == ColLast) || (row_w == '0) || (row_w == RowLast);
    end else if ((col_w == 11'd0) || (col_w == 11'd1) || (col_w == ColLast) ||
                 (col_w == ColLast2)) begin
      edge_drop = 1'b1;
    end else if (cfg_i.sensor_type == pmss_pkg::SensorUpDown) begin
      edge_drop = (!odd && row_w == '0) || (odd && row_w == RowLast);
    end else if (cfg_i.sensor_type == pmss_pkg::SensorDownUp) begin
      edge_drop = (odd && row_w == '0) || (!odd && row_w == RowLast);
    end else begin
      edge_drop = 1'b0;
    end

    // serial: ToT walks rows in pairs of column quads, else 8x8 cores with a
    // per core-row column rotation
    blk_row  = s1_row_q[8:3];
    core_col = s1_col_q[2:0] + blk_row[2:0];
    if (cfg_i.mask_type == pmss_pkg::MaskTot) begin
      s2_serial_d = {2'b00, s1_row_q, s1_col_q[2]};
    end else begin
      s2_serial_d = {blk_row, core_col, s1_row_q[2:0]};
    end

    xtalk = (cfg_i.mask_type == pmss_pkg::MaskXtalkNb) ||
            (cfg_i.mask_type == pmss_pkg::MaskXtalkCentre);
    pat   = pmss_pkg::NbPatternBits[cfg_i.nb_pattern];
    for (int i = 0; i < int'(pmss_pkg::NbSlots); i++) begin
      dc = pmss_pkg::NbDcol[cfg_i.sensor_type][odd][i];
      dr = pmss_pkg::NbDrow[cfg_i.sensor_type][odd][i];
      nc = $signed({3'b000, s1_col_q}) + $signed({{9{dc[2]}}, dc});
      nr = $signed({3'b000, s1_row_q}) + $signed({{9{dr[2]}}, dr});
      s2_item_d.nb_mask[i] = pat[i] && xtalk &&
                             (cfg_i.sensor_type != pmss_pkg::SensorOther) &&
                             !nc[11] && (nc[10:0] < ColLim) &&
                             !nr[11] && (nr[10:0] < RowLim);
    end

    s2_item_d.col = s1_col_q;
    s2_item_d.row = s1_row_q;
    s2_item_d.ok  = in_bounds && !edge_drop && (!cfg_i.apply_enable || s1_en_q);
  end

  assign out_valid_o  = s2_valid_q;
  assign out_item_o   = s2_item_q;
  assign out_serial_o = s2_serial_q;

endmodule

`default_nettype wire

// File: src/pmss_rem_stage.sv
`default_nettype none

// Restoring remainder, a few dividend bits per stage; quotient is not kept.
module pmss_rem_stage (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [pmss_pkg::StageCntW-1:0]     stage_count_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire pmss_pkg::item_t                    in_item_i,
  input  wire logic [pmss_pkg::StageW-1:0]        in_rem_i,
  input  wire logic [pmss_pkg::SerialW-1:0]       in_div_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output pmss_pkg::item_t                         out_item_o,
  output logic [pmss_pkg::StageW-1:0]             out_rem_o,
  output logic [pmss_pkg::SerialW-1:0]            out_div_o
);

  logic                           valid_q, valid_d;
  pmss_pkg::item_t                item_q;
  logic [pmss_pkg::StageW-1:0]    rem_q, rem_d;
  logic [pmss_pkg::SerialW-1:0]   div_q, div_d;
  logic                           ready;

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;
  assign valid_d    = ready ? in_valid_i : valid_q;

  always_comb begin
    logic [pmss_pkg::StageCntW-1:0] t;
    rem_d = in_rem_i;
    div_d = in_div_i;
    for (int k = 0; k < int'(pmss_pkg::RemBitsStep); k++) begin
      t     = {rem_d, div_d[pmss_pkg::SerialW-1]};
      div_d = {div_d[pmss_pkg::SerialW-2:0], 1'b0};
      if (t >= stage_count_i) begin
        t = t - stage_count_i;
      end
      // remainder stays below 4096 whatever the modulus
      rem_d = t[pmss_pkg::StageW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready) begin
      item_q <= in_item_i;
      rem_q  <= rem_d;
      div_q  <= div_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;
  assign out_rem_o   = rem_q;
  assign out_div_o   = div_q;

endmodule

`default_nettype wire

// File: src/pmss_expand.sv
`default_nettype none

// Holds one selected pixel and emits its centre result, then one result per
// neighbour, into the output register.
module pmss_expand (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pmss_pkg::cfg_t                cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire pmss_pkg::item_t               in_item_i,
  input  wire logic [pmss_pkg::StageW-1:0]   in_rem_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [pmss_pkg::ColW-1:0]          out_col_o,
  output logic [pmss_pkg::RowW-1:0]          out_row_o,
  output logic                               out_en_o,
  output logic                               out_inj_o,
  output logic                               out_hb_o,
  output logic                               out_last_o
);

  logic                             h_valid_q, h_valid_d;
  logic                             h_centre_q, h_centre_d;
  logic [pmss_pkg::ColW-1:0]        h_col_q;
  logic [pmss_pkg::RowW-1:0]        h_row_q;
  logic [pmss_pkg::NbSlots-1:0]     h_mask_q, h_mask_d;
  logic                             o_valid_q, o_valid_d;
  logic [pmss_pkg::ColW-1:0]        o_col_q, e_col;
  logic [pmss_pkg::RowW-1:0]        o_row_q, e_row;
  logic                             o_en_q, e_en;
  logic                             o_inj_q, e_inj;
  logic                             o_hb_q, e_hb;
  logic                             o_last_q, e_last;
  logic                             sel, out_free, push, done, load;

  assign sel = in_item_i.ok && (cfg_i.stage_count != '0) &&
               (in_rem_i == cfg_i.current_stage);

  assign out_free   = !o_valid_q || out_ready_i;
  assign push       = h_valid_q && out_free;
  assign done       = push && e_last;
  assign in_ready_o = !h_valid_q || done;
  assign load       = in_valid_i && in_ready_o && sel;

  always_comb begin
    logic [pmss_pkg::NbSlots-1:0] low;
    logic [2:0]                   idx;
    pmss_pkg::nb_off_t            dc;
    pmss_pkg::nb_off_t            dr;

    low = h_mask_q & (~h_mask_q + 8'd1);
    idx = 3'd0;
    for (int i = 0; i < int'(pmss_pkg::NbSlots); i++) begin
      if (low[i]) begin
        idx = 3'(i);
      end
    end
    dc = pmss_pkg::NbDcol[cfg_i.sensor_type][h_col_q[0]][idx];
    dr = pmss_pkg::NbDrow[cfg_i.sensor_type][h_col_q[0]][idx];

    h_mask_d   = h_mask_q;
    h_centre_d = h_centre_q;

    if (h_centre_q) begin
      e_col  = h_col_q;
      e_row  = h_row_q;
      e_last = (h_mask_q == '0);
      case (cfg_i.mask_type)
        pmss_pkg::MaskStd:         {e_en, e_inj, e_hb} = 3'b111;
        pmss_pkg::MaskXtalkNb:     {e_en, e_inj, e_hb} = 3'b101;
        pmss_pkg::MaskXtalkCentre: {e_en, e_inj, e_hb} = 3'b010;
        default:                   {e_en, e_inj, e_hb} = 3'b011;
      endcase
      if (push) begin
        h_centre_d = 1'b0;
      end
    end else begin
      e_col  = h_col_q + {{6{dc[2]}}, dc};
      e_row  = h_row_q + {{6{dr[2]}}, dr};
      e_last = ((h_mask_q & ~low) == '0);
      if (cfg_i.mask_type == pmss_pkg::MaskXtalkNb) begin
        {e_en, e_inj, e_hb} = 3'b010;
      end else begin
        {e_en, e_inj, e_hb} = 3'b101;
      end
      if (push) begin
        h_mask_d = h_mask_q & ~low;
      end
    end

    if (load) begin
      h_mask_d   = in_item_i.nb_mask;
      h_centre_d = 1'b1;
    end
  end

  assign h_valid_d = load ? 1'b1 : (done ? 1'b0 : h_valid_q);
  assign o_valid_d = push ? 1'b1 : (out_ready_i ? 1'b0 : o_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      h_valid_q <= h_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_mask_q   <= h_mask_d;
    h_centre_q <= h_centre_d;
    if (load) begin
      h_col_q <= in_item_i.col;
      h_row_q <= in_item_i.row;
    end
    if (push) begin
      o_col_q  <= e_col;
      o_row_q  <= e_row;
      o_en_q   <= e_en;
      o_inj_q  <= e_inj;
      o_hb_q   <= e_hb;
      o_last_q <= e_last;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_col_o   = o_col_q;
  assign out_row_o   = o_row_q;
  assign out_en_o    = o_en_q;
  assign out_inj_o   = o_inj_q;
  assign out_hb_o    = o_hb_q;
  assign out_last_o  = o_last_q;

endmodule

`default_nettype wire

// File: src/pixel_mask_stage_selector_top.sv
// Pixel mask stage selector.
// s_axis carries one pixel (column, row, original enable) per item. For each
// pixel that lies on the sensor, passes the edge and enable filters and whose
// serial modulo stage_count equals current_stage, m_axis gives a centre result
// and, in the two cross-talk modes on a square, up-down or down-up sensor, one
// result per in-bounds neighbour of the chosen pattern. tlast marks the last result
// of a pixel; rejected pixels give nothing. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only while no item is in
// flight, as the block does not enforce this. The first result of a pixel passes
// through two qualify stages, three remainder stages retiring four serial bits each,
// the expansion register and the output register.
// Throughput: m_axis moves one result per cycle while m_axis_tready is high, so a
// pixel holds the expansion register until its centre result and each neighbour result
// have moved out; the other stages take an item every cycle when not stalled.
// Reset clears all valid bits and loads register defaults (stage_count 64,
// neighbour_pattern 1, others 0). When m_axis_tready is low the output
// register holds its result and backpressure ripples back to s_axis_tready;
// nothing is dropped or repeated.
`default_nettype none

module pixel_mask_stage_selector_top #(
  parameter int unsigned COLUMNS = 400,
  parameter int unsigned ROWS    = 384
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [23:0]  s_axis_tdata,   // pixel_col, pixel_row, pixel_enabled, zero pad
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // out_col, out_row, enable_bit, inject_bit,
                                            // hitbus_bit, zero pad
  output logic              m_axis_tlast,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [12:0]  cfg_data_i
);

  pmss_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmss_pkg::RegMaskType:     cfg_d.mask_type     = pmss_pkg::mask_type_e'(cfg_data_i[1:0]);
        pmss_pkg::RegNbPattern:    cfg_d.nb_pattern    = cfg_data_i[3:0];
        pmss_pkg::RegSensorType:   cfg_d.sensor_type   = cfg_data_i[1:0];
        pmss_pkg::RegEdgeMode:     cfg_d.edge_mode     = cfg_data_i[1:0];
        pmss_pkg::RegStageCount:   cfg_d.stage_count   = cfg_data_i;
        pmss_pkg::RegCurrentStage: cfg_d.current_stage = cfg_data_i[11:0];
        pmss_pkg::RegApplyEnable:  cfg_d.apply_enable  = cfg_data_i[0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask_type     <= pmss_pkg::MaskStd;
      cfg_q.nb_pattern    <= 4'd1;
      cfg_q.sensor_type   <= pmss_pkg::SensorSquare;
      cfg_q.edge_mode     <= pmss_pkg::EdgeKeep;
      cfg_q.stage_count   <= 13'd64;
      cfg_q.current_stage <= '0;
      cfg_q.apply_enable  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic                           f_valid, f_ready;
  pmss_pkg::item_t                f_item;
  logic [pmss_pkg::SerialW-1:0]   f_serial;
  logic                           r1_valid, r1_ready, r2_valid, r2_ready, r3_valid, r3_ready;
  pmss_pkg::item_t                r1_item, r2_item, r3_item;
  logic [pmss_pkg::StageW-1:0]    r1_rem, r2_rem, r3_rem;
  logic [pmss_pkg::SerialW-1:0]   r1_div, r2_div, r3_div;
  logic [pmss_pkg::ColW-1:0]      o_col;
  logic [pmss_pkg::RowW-1:0]      o_row;
  logic                           o_en, o_inj, o_hb;

  pmss_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_col_i     (s_axis_tdata[8:0]),
    .in_row_i     (s_axis_tdata[17:9]),
    .in_en_i      (s_axis_tdata[18]),
    .out_valid_o  (f_valid),
    .out_ready_i  (f_ready),
    .out_item_o   (f_item),
    .out_serial_o (f_serial)
  );

  pmss_rem_stage u_rem1 (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_count_i (cfg_q.stage_count),
    .in_valid_i    (f_valid),
    .in_ready_o    (f_ready),
    .in_item_i     (f_item),
    .in_rem_i      ('0),
    .in_div_i      (f_serial),
    .out_valid_o   (r1_valid),
    .out_ready_i   (r1_ready),
    .out_item_o    (r1_item),
    .out_rem_o     (r1_rem),
    .out_div_o     (r1_div)
  );

  pmss_rem_stage u_rem2 (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_count_i (cfg_q.stage_count),
    .in_valid_i    (r1_valid),
    .in_ready_o    (r1_ready),
    .in_item_i     (r1_item),
    .in_rem_i      (r1_rem),
    .in_div_i      (r1_div),
    .out_valid_o   (r2_valid),
    .out_ready_i   (r2_ready),
    .out_item_o    (r2_item),
    .out_rem_o     (r2_rem),
    .out_div_o     (r2_div)
  );

  pmss_rem_stage u_rem3 (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_count_i (cfg_q.stage_count),
    .in_valid_i    (r2_valid),
    .in_ready_o    (r2_ready),
    .in_item_i     (r2_item),
    .in_rem_i      (r2_rem),
    .in_div_i      (r2_div),
    .out_valid_o   (r3_valid),
    .out_ready_i   (r3_ready),
    .out_item_o    (r3_item),
    .out_rem_o     (r3_rem),
    .out_div_o     (r3_div)
  );

  pmss_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (r3_valid),
    .in_ready_o  (r3_ready),
    .in_item_i   (r3_item),
    .in_rem_i    (r3_rem),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_col_o   (o_col),
    .out_row_o   (o_row),
    .out_en_o    (o_en),
    .out_inj_o   (o_inj),
    .out_hb_o    (o_hb),
    .out_last_o  (m_axis_tlast)
  );

  // all serial bits are retired after the third stage
  logic r3_div_unused;
  assign r3_div_unused = ^r3_div;

  assign m_axis_tdata = {3'b000, o_hb, o_inj, o_en, o_row, o_col};

endmodule

`default_nettype wire

// File: src/pmss_checker.sv
`default_nettype none

module pmss_checker #(
  parameter int unsigned COLUMNS = 400,
  parameter int unsigned ROWS    = 384
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_valid_i,
  input wire logic        m_ready_i,
  input wire logic [23:0] m_data_i,
  input wire logic        m_last_i
);

  localparam logic [10:0] ColLim = 11'(COLUMNS);
  localparam logic [10:0] RowLim = 11'(ROWS);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_ready_i |=> m_valid_i && $stable(m_data_i) && $stable(m_last_i))
    else $error("stalled result changed");

  // every result enables readout or injection, and readout always brings hitbus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i |-> (m_data_i[18] || m_data_i[19]) && (!m_data_i[18] || m_data_i[20]))
    else $error("illegal enable/inject/hitbus combination");

  // results, neighbours included, never leave the sensor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i |-> ({2'b00, m_data_i[8:0]} < ColLim) && ({2'b00, m_data_i[17:9]} < RowLim))
    else $error("result coordinate off the sensor");

  // output register is cleared by reset
  assert property (@(posedge clk_i) !rst_ni |=> !m_valid_i)
    else $error("result valid after reset");

endmodule

bind pixel_mask_stage_selector_top pmss_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_pmss_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_valid_i (m_axis_tvalid),
  .m_ready_i (m_axis_tready),
  .m_data_i  (m_axis_tdata),
  .m_last_i  (m_axis_tlast)
);

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int SensorCols = 400;
  localparam int SensorRows = 384;
  localparam int LongHoldCycles = 400;
  localparam int SettleCycles = 12;

  // neighbour offsets by slot; rectangular rows depend on sensor type and parity
  localparam int SqDc [8]       = '{0, 1, 1, 1, 0, -1, -1, -1};
  localparam int SqDr [8]       = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int RectDcEven [8] = '{1, 3, 2, 3, 1, -1, -2, -1};
  localparam int RectDcOdd [8]  = '{-1, 1, 2, 1, -1, -3, -2, -3};
  localparam int RowDn [8]      = '{0, 0, 0, -1, -1, -1, 0, 0};
  localparam int RowUp [8]      = '{1, 1, 0, 0, 0, 0, 0, 1};
  localparam logic [7:0] NbSelect [16] = '{
    8'hFF, 8'h55, 8'h11, 8'h44, 8'h10, 8'h01, 8'h04, 8'h40,
    8'h08, 8'h20, 8'h02, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [8:0] col;
    logic [8:0] row;
    logic       en;
    logic       inj;
    logic       hb;
    logic       last;
  } pix_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;

  // register shadow, reset values
  pmss_pkg::mask_type_e m_type = pmss_pkg::MaskStd;
  logic [3:0]  nb_pat = 4'd1;
  logic [1:0]  sens = pmss_pkg::SensorSquare;
  logic [1:0]  edge_md = pmss_pkg::EdgeKeep;
  logic [12:0] st_count = 13'd64;
  logic [11:0] cur_stage = '0;
  logic        en_mask = 1'b0;

  logic [23:0] pixel_q [$];
  pix_write_t  pix_writes_q [$];
  int          fail_count = 0;

  int          gap_max = 0;
  int          burst_left = 1;
  int          idle_left = 0;
  int          rx_mode = 0;
  int          rx_cyc = 0;
  int          hold_cnt = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;

  pixel_mask_stage_selector_top #(
    .COLUMNS(SensorCols),
    .ROWS   (SensorRows)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pixel_serial(int unsigned c, int unsigned r);
    int unsigned cr;
    if (m_type == pmss_pkg::MaskTot) return r * 2 + (c % 8) / 4;
    cr = r / 8;
    return cr * 64 + ((c + cr % 8) % 8) * 8 + r % 8;
  endfunction

  function automatic bit at_excluded_edge(int unsigned c, int unsigned r);
    if (edge_md == pmss_pkg::EdgeCorner) return !(c == 0 && r == 0);
    if (edge_md == pmss_pkg::EdgeKeep) return 1'b0;
    if (sens == pmss_pkg::SensorSquare)
      return c == 0 || c == SensorCols - 1 || r == 0 || r == SensorRows - 1;
    if (c <= 1 || c >= SensorCols - 2) return 1'b1;
    if (sens == pmss_pkg::SensorUpDown)
      return (c % 2 == 0 && r == 0) || (c % 2 == 1 && r == SensorRows - 1);
    if (sens == pmss_pkg::SensorDownUp)
      return (c % 2 == 1 && r == 0) || (c % 2 == 0 && r == SensorRows - 1);
    return 1'b0;
  endfunction

  function automatic bit pixel_selected(int unsigned c, int unsigned r, bit e);
    if (c >= SensorCols || r >= SensorRows) return 1'b0;
    if (at_excluded_edge(c, r)) return 1'b0;
    if (st_count == 0) return 1'b0;
    if (pixel_serial(c, r) % st_count != cur_stage) return 1'b0;
    return !(en_mask && !e);
  endfunction

  // expected pixel writes for one input pixel
  task automatic predict_pixel_writes(input int unsigned c, input int unsigned r, input bit e);
    pix_write_t batch [$];
    pix_write_t w;
    logic [7:0] sel;
    int nc, nr, dc, dr;
    bit nb_inj;
    if (!pixel_selected(c, r, e)) return;
    w = '{col: c[8:0], row: r[8:0], en: 1'b1, inj: 1'b1, hb: 1'b1, last: 1'b0};
    if (m_type == pmss_pkg::MaskXtalkNb || m_type == pmss_pkg::MaskXtalkCentre) begin
      nb_inj = (m_type == pmss_pkg::MaskXtalkNb);
      w.en = nb_inj;
      w.inj = !nb_inj;
      w.hb = nb_inj;
      batch.insert(batch.size(), w);
      sel = NbSelect[nb_pat];
      if (sens != pmss_pkg::SensorOther) begin
        for (int i = 0; i < 8; i++) begin
          if (!sel[i]) continue;
          if (sens == pmss_pkg::SensorSquare) begin
            dc = SqDc[i];
            dr = SqDr[i];
          end else begin
            dc = (c % 2 == 1) ? RectDcOdd[i] : RectDcEven[i];
            // up-down even and down-up odd columns reach one row down
            dr = ((sens == pmss_pkg::SensorUpDown) == (c % 2 == 0)) ? RowDn[i] : RowUp[i];
          end
          nc = int'(c) + dc;
          nr = int'(r) + dr;
          if (nc < 0 || nr < 0 || nc > SensorCols - 1 || nr > SensorRows - 1) continue;
          w.col = nc[8:0];
          w.row = nr[8:0];
          w.en = !nb_inj;
          w.inj = nb_inj;
          w.hb = !nb_inj;
          batch.insert(batch.size(), w);
        end
      end
    end else begin
      w.en = (m_type != pmss_pkg::MaskTot);
      batch.insert(batch.size(), w);
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) pix_writes_q.insert(pix_writes_q.size(), batch[k]);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned got);
    if (exp_v != got) begin
      $error("%s expected %0d got %0d", name, exp_v, got);
      fail_count++;
    end
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (idle_left > 0) begin
        s_axis_tvalid <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pixel_q.size() != 0) begin
        s_axis_tdata <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          idle_left <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern per phase, plus one long hold-off
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= LongHoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_cyc % 7 < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    pix_write_t w;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        predict_pixel_writes(s_axis_tdata[8:0], s_axis_tdata[17:9], s_axis_tdata[18]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pix_writes_q.size() == 0) begin
          $error("unexpected item col %0d row %0d", m_axis_tdata[8:0], m_axis_tdata[17:9]);
          fail_count++;
        end else begin
          w = pix_writes_q.pop_front();
          check_field("out_col", w.col, m_axis_tdata[8:0]);
          check_field("out_row", w.row, m_axis_tdata[17:9]);
          check_field("enable_bit", w.en, m_axis_tdata[18]);
          check_field("inject_bit", w.inj, m_axis_tdata[19]);
          check_field("hitbus_bit", w.hb, m_axis_tdata[20]);
          check_field("is_last", w.last, m_axis_tlast);
        end
      end
    end
  end

  task automatic write_reg(input pmss_pkg::cfg_reg_e idx, input logic [12:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      pmss_pkg::RegMaskType:     m_type = pmss_pkg::mask_type_e'(val[1:0]);
      pmss_pkg::RegNbPattern:    nb_pat = val[3:0];
      pmss_pkg::RegSensorType:   sens = val[1:0];
      pmss_pkg::RegEdgeMode:     edge_md = val[1:0];
      pmss_pkg::RegStageCount:   st_count = val;
      pmss_pkg::RegCurrentStage: cur_stage = val[11:0];
      default:                   en_mask = val[0];
    endcase
  endtask

  task automatic apply_config(input int mt, input int pat, input int st, input int em,
                              input int cnt, input int stage, input int msk);
    write_reg(pmss_pkg::RegMaskType, 13'(mt));
    write_reg(pmss_pkg::RegNbPattern, 13'(pat));
    write_reg(pmss_pkg::RegSensorType, 13'(st));
    write_reg(pmss_pkg::RegEdgeMode, 13'(em));
    write_reg(pmss_pkg::RegStageCount, 13'(cnt));
    write_reg(pmss_pkg::RegCurrentStage, 13'(stage));
    write_reg(pmss_pkg::RegApplyEnable, 13'(msk));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait for every result, then let rejected items clear the pipeline
  task automatic drain();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || s_axis_tvalid || pix_writes_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic add_pixel(input int unsigned c, input int unsigned r, input bit e);
    pixel_q.insert(pixel_q.size(), {5'd0, e, r[8:0], c[8:0]});
  endtask

  function automatic int unsigned rand_col();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 15) return (p % 2) ? $urandom_range(0, 2) : $urandom_range(SensorCols - 3, SensorCols - 1);
    if (p < 23) return $urandom_range(SensorCols, 511);
    return $urandom_range(0, SensorCols - 1);
  endfunction

  function automatic int unsigned rand_row();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 15) return (p % 2) ? $urandom_range(0, 1) : $urandom_range(SensorRows - 2, SensorRows - 1);
    if (p < 21) return $urandom_range(SensorRows, 511);
    return $urandom_range(0, SensorRows - 1);
  endfunction

  // mostly pixels that land in the current stage, the rest noise
  task automatic add_random_pixels(input int n);
    int unsigned c, r;
    bit e;
    bit want_hit;
    for (int i = 0; i < n; i++) begin
      want_hit = ($urandom_range(0, 99) < 75);
      c = rand_col();
      r = rand_row();
      e = 1'($urandom_range(0, 1));
      if (want_hit) begin
        for (int t = 0; t < 600 && !pixel_selected(c, r, e); t++) begin
          c = rand_col();
          r = rand_row();
          e = ($urandom_range(0, 7) != 0);
        end
      end
      add_pixel(c, r, e);
    end
  endtask

  function automatic int rand_stage_count();
    case ($urandom_range(0, 11))
      0, 1:    return 1;
      2:       return 2;
      3:       return 3;
      4:       return 4;
      5:       return 8;
      6, 7:    return 64;
      8:       return 4096;
      9:       return 8191;
      10:      return 0;
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  initial begin
    int cnt;
    int stage;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    rx_mode = 0;

    // reset settings: standard mask, 64 stages, stage 0
    add_pixel(0, 0, 1);
    add_pixel(SensorCols - 1, SensorRows - 1, 1);
    add_pixel(511, 511, 0);
    add_pixel(SensorCols, 0, 1);
    add_pixel(0, SensorRows, 1);
    add_pixel(0, 0, 0);
    drain();

    // all neighbours on a square sensor, enable filter on
    apply_config(pmss_pkg::MaskXtalkNb, 0, pmss_pkg::SensorSquare, pmss_pkg::EdgeKeep, 1, 0, 1);
    add_pixel(0, 0, 1);
    add_pixel(SensorCols - 1, SensorRows - 1, 1);
    add_pixel(200, 100, 1);
    add_pixel(200, 100, 0);
    add_pixel(511, 0, 1);
    drain();

    // up-down sensor with edge removal
    rx_mode = 1;
    apply_config(pmss_pkg::MaskXtalkCentre, 0, pmss_pkg::SensorUpDown, 1, 1, 0, 0);
    add_pixel(1, 5, 1);
    add_pixel(2, 0, 1);
    add_pixel(3, 0, 1);
    add_pixel(3, SensorRows - 1, 1);
    add_pixel(2, SensorRows - 1, 1);
    add_pixel(SensorCols - 3, 200, 1);
    drain();

    // down-up sensor, edge mode three acts as removal
    apply_config(pmss_pkg::MaskXtalkNb, 0, pmss_pkg::SensorDownUp, 3, 1, 0, 0);
    add_pixel(2, 0, 1);
    add_pixel(3, 0, 1);
    add_pixel(2, SensorRows - 1, 1);
    add_pixel(3, SensorRows - 1, 0);
    add_pixel(100, 100, 1);
    drain();

    // unused sensor type and pattern beyond eleven, corner only
    apply_config(pmss_pkg::MaskXtalkCentre, 13, pmss_pkg::SensorOther, pmss_pkg::EdgeCorner,
                 1, 0, 0);
    add_pixel(0, 0, 1);
    add_pixel(5, 5, 1);
    drain();

    // ToT with zero stage count, then the widest stage settings
    apply_config(pmss_pkg::MaskTot, 11, pmss_pkg::SensorSquare, pmss_pkg::EdgeKeep, 0, 0, 0);
    add_pixel(0, 0, 1);
    add_pixel(10, 10, 1);
    drain();
    apply_config(pmss_pkg::MaskTot, 15, pmss_pkg::SensorSquare, pmss_pkg::EdgeKeep, 4096, 5, 1);
    add_pixel(4, 2, 1);
    add_pixel(3, 2, 1);
    drain();
    apply_config(pmss_pkg::MaskStd, 12, pmss_pkg::SensorOther, 3, 8191, 4095, 0);
    add_pixel(200, 200, 1);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 2) begin
        // receiver holds off while the sender keeps offering: the block backs up
        apply_config(pmss_pkg::MaskXtalkNb, 0, pmss_pkg::SensorSquare, pmss_pkg::EdgeKeep,
                     1, 0, 0);
        gap_max = 0;
        rx_mode = 0;
        hold_req = 1'b1;
        add_random_pixels(40);
      end else begin
        cnt = rand_stage_count();
        stage = (cnt > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, cnt - 1) % 4096
                                                         : $urandom_range(0, 4095);
        apply_config($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 3),
                     $urandom_range(0, 3), cnt, stage, $urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0:       gap_max = 0;
          1:       gap_max = 3;
          2:       gap_max = 8;
          default: gap_max = 1;
        endcase
        rx_mode = $urandom_range(0, 3);
        add_random_pixels(28);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
src/pmss_pkg.sv
src/pmss_front.sv
src/pmss_rem_stage.sv
src/pmss_expand.sv
src/pixel_mask_stage_selector_top.sv
src/pmss_checker.sv
verif/testbench.sv
